### hdl/per_type_record_statistics_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-type record statistics block.
// Each macro checks an implication on the rising clock edge outside reset.
// ----------------------------------------------------------------------------
`ifndef PER_TYPE_RECORD_STATISTICS_DEFINES_SVH
`define PER_TYPE_RECORD_STATISTICS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Types and constants shared by the record statistics modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pst_pkg;

  localparam logic [1:0] REQ_DGRAM  = 2'd0;
  localparam logic [1:0] REQ_RECORD = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [5:0] SEL_TRANS   = 6'd0;
  localparam logic [5:0] SEL_ENTRIES = 6'd1;
  localparam logic [5:0] SEL_ZERO    = 6'd2;
  localparam logic [5:0] SEL_PMIN    = 6'd3;
  localparam logic [5:0] SEL_PMAX    = 6'd4;
  localparam logic [5:0] SEL_VMIN    = 6'd5;
  localparam logic [5:0] SEL_VMAX    = 6'd6;
  localparam logic [5:0] SEL_LMIN    = 6'd7;
  localparam logic [5:0] SEL_LMAX    = 6'd8;
  localparam logic [5:0] SEL_SMIN    = 6'd9;
  localparam logic [5:0] SEL_SMAX    = 6'd10;
  localparam logic [5:0] SEL_LVMIN   = 6'd11;
  localparam logic [5:0] SEL_LVMAX   = 6'd12;
  localparam logic [5:0] SEL_DMIN    = 6'd13;
  localparam logic [5:0] SEL_DMAX    = 6'd14;
  localparam logic [5:0] SEL_DTOTAL  = 6'd15;
  localparam logic [5:0] SEL_TB_BASE = 6'd16;
  localparam logic [5:0] SEL_BT_BASE = 6'd33;
  localparam logic [5:0] SEL_LAST    = 6'd49;

  localparam int STOP_BIT = 15;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  transition_id;
    logic [63:0] time_stamp;
    logic [6:0]  type_id;
    logic [30:0] payload_size;
    logic [14:0] type_version;
    logic [23:0] source_log;
    logic [31:0] source_phy;
    logic [7:0]  source_level;
    logic [7:0]  nest_depth;
    logic [31:0] damage_word;
    logic [5:0]  stat_select;
  } pst_in_t;

  typedef struct packed {
    logic        time_out_of_order;
    logic        any_damage;
    logic        stop_walk;
    logic [31:0] read_value;
  } pst_out_t;

  typedef struct packed {
    logic [31:0] entries;
    logic [31:0] zero_cnt;
    logic [31:0] dmg_total;
    logic [30:0] pay_min;
    logic [30:0] pay_max;
    logic [14:0] ver_min;
    logic [14:0] ver_max;
    logic [23:0] log_min;
    logic [23:0] log_max;
    logic [31:0] phy_min;
    logic [31:0] phy_max;
    logic [23:0] lvl_min;
    logic [7:0]  lvl_max;
    logic [23:0] dep_min;
    logic [7:0]  dep_max;
  } stat_row_t;

  localparam stat_row_t STAT_ROW_RESET = '{
    entries:   32'd0,
    zero_cnt:  32'd0,
    dmg_total: 32'd0,
    pay_min:   31'd11111111,
    pay_max:   31'd0,
    ver_min:   15'd111,
    ver_max:   15'd0,
    log_min:   24'd11111111,
    log_max:   24'd0,
    phy_min:   32'd1111111111,
    phy_max:   32'd0,
    lvl_min:   24'd11111111,
    lvl_max:   8'd0,
    dep_min:   24'd11111111,
    dep_max:   8'd0
  };

  typedef struct packed {
    logic rd;
    logic upd_rec;
    logic upd_dgram;
  } pst_ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } pst_state_t;

endpackage

### hdl/pst_type_table.sv
// ----------------------------------------------------------------------------
// pst_type_table
// Per-type statistics and per-type damage counters held in two memories,
// cleared by a sweep after reset and updated by read-modify-write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pst_type_table
  import pst_pkg::*;
#(
  parameter int NUM_TYPES   = 128,
  parameter int DAMAGE_BITS = 17,
  parameter int TYPE_AW     = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pst_ctl_t                     ctl,
  input  logic [TYPE_AW-1:0]           rd_addr,
  input  pst_in_t                      rec,
  output logic                         clearing,
  output stat_row_t                    stat_q,
  output logic [DAMAGE_BITS-1:0][31:0] dmg_q
);

  localparam int CNT_W = $clog2(DAMAGE_BITS + 1);

  stat_row_t                    stat_mem [NUM_TYPES];
  logic [DAMAGE_BITS-1:0][31:0] dmg_mem  [NUM_TYPES];

  logic [TYPE_AW-1:0]           clr_cnt;
  logic [TYPE_AW-1:0]           addr_q;
  stat_row_t                    stat_upd;
  logic [DAMAGE_BITS-1:0][31:0] dmg_upd;
  logic [CNT_W-1:0]             pop;
  logic                         wr_en;
  logic [TYPE_AW-1:0]           wr_addr;
  stat_row_t                    wr_stat;
  logic [DAMAGE_BITS-1:0][31:0] wr_dmg;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == TYPE_AW'(NUM_TYPES - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    pop = '0;
    for (int b = 0; b < DAMAGE_BITS; b++) begin
      pop = pop + CNT_W'(rec.damage_word[b]);
      dmg_upd[b] = dmg_q[b] + {31'd0, rec.damage_word[b]};
    end
    stat_upd = stat_q;
    stat_upd.entries   = stat_q.entries + 32'd1;
    stat_upd.dmg_total = stat_q.dmg_total + 32'(pop);
    if (rec.payload_size == '0) begin
      stat_upd.zero_cnt = stat_q.zero_cnt + 32'd1;
    end
    if (rec.payload_size < stat_q.pay_min) stat_upd.pay_min = rec.payload_size;
    if (rec.payload_size > stat_q.pay_max) stat_upd.pay_max = rec.payload_size;
    if (rec.type_version < stat_q.ver_min) stat_upd.ver_min = rec.type_version;
    if (rec.type_version > stat_q.ver_max) stat_upd.ver_max = rec.type_version;
    if (rec.source_log < stat_q.log_min) stat_upd.log_min = rec.source_log;
    if (rec.source_log > stat_q.log_max) stat_upd.log_max = rec.source_log;
    if (rec.source_phy < stat_q.phy_min) stat_upd.phy_min = rec.source_phy;
    if (rec.source_phy > stat_q.phy_max) stat_upd.phy_max = rec.source_phy;
    if (24'(rec.source_level) < stat_q.lvl_min) stat_upd.lvl_min = 24'(rec.source_level);
    if (rec.source_level > stat_q.lvl_max) stat_upd.lvl_max = rec.source_level;
    if (24'(rec.nest_depth) < stat_q.dep_min) stat_upd.dep_min = 24'(rec.nest_depth);
    if (rec.nest_depth > stat_q.dep_max) stat_upd.dep_max = rec.nest_depth;
  end

  always_comb begin
    wr_en   = clearing || ctl.upd_rec;
    wr_addr = clearing ? clr_cnt : addr_q;
    wr_stat = clearing ? STAT_ROW_RESET : stat_upd;
    wr_dmg  = clearing ? '0 : dmg_upd;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stat_mem[wr_addr] <= wr_stat;
      dmg_mem[wr_addr]  <= wr_dmg;
    end
    if (ctl.rd) begin
      addr_q <= rd_addr;
      stat_q <= stat_mem[rd_addr];
      dmg_q  <= dmg_mem[rd_addr];
    end
  end

endmodule

### hdl/pst_global.sv
// ----------------------------------------------------------------------------
// pst_global
// Transition counters, per-bit damage totals and the previous datagram time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pst_global
  import pst_pkg::*;
#(
  parameter int NUM_TRANSITIONS = 32,
  parameter int DAMAGE_BITS     = 17,
  parameter int TRANS_AW        = 5,
  parameter int BIT_AW          = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  pst_ctl_t    ctl,
  input  pst_in_t     rec,
  output logic        late,
  output logic [31:0] trans_val,
  output logic [31:0] bit_val
);

  logic [31:0]         trans_cnt [NUM_TRANSITIONS];
  logic [31:0]         bit_tot   [DAMAGE_BITS];
  logic [63:0]         prev_time;
  logic                tr_ok;
  logic [TRANS_AW-1:0] tr_idx;
  logic [5:0]          bidx;
  logic                bit_ok;

  always_comb begin
    tr_ok     = int'(rec.transition_id) < NUM_TRANSITIONS;
    tr_idx    = TRANS_AW'(rec.transition_id);
    late      = prev_time > rec.time_stamp;
    trans_val = tr_ok ? trans_cnt[tr_idx] : 32'd0;
    bidx      = rec.stat_select - SEL_BT_BASE;
    bit_ok    = (rec.stat_select >= SEL_BT_BASE) && (rec.stat_select <= SEL_LAST)
                && (int'(bidx) < DAMAGE_BITS);
    bit_val   = bit_ok ? bit_tot[bidx[BIT_AW-1:0]] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      for (int i = 0; i < NUM_TRANSITIONS; i++) trans_cnt[i] <= '0;
      for (int b = 0; b < DAMAGE_BITS; b++) bit_tot[b] <= '0;
    end else begin
      if (ctl.upd_dgram) begin
        prev_time <= rec.time_stamp;
        if (tr_ok) trans_cnt[tr_idx] <= trans_cnt[tr_idx] + 32'd1;
      end
      if (ctl.upd_rec) begin
        for (int b = 0; b < DAMAGE_BITS; b++) begin
          bit_tot[b] <= bit_tot[b] + {31'd0, rec.damage_word[b]};
        end
      end
    end
  end

endmodule

### hdl/per_type_record_statistics.sv
// ----------------------------------------------------------------------------
// per_type_record_statistics
// Quality-check statistics over data-acquisition datagrams and records.
// ----------------------------------------------------------------------------
// A request beat is taken on a rising edge with start high and busy low.
// Requests are datagrams (count transition, check time order), records
// (update the per-type row and damage counters) or reads of one statistic.
// Every request gives one result beat: done is high for exactly one cycle
// with the result on rsp; both are registered from the ST_EXEC state that
// follows the accepting edge.
// The receiver cannot stall, so results are never held back.
// Each request first reads the type row synchronously, then modifies it and
// writes it back, during which busy is high. The next request can be taken
// in the cycle in which done is shown.
// After reset the type memories are swept to their initial values, one row
// per cycle, and busy stays high until the sweep ends. Transition counters,
// bit totals and the previous time clear at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_type_record_statistics
  import pst_pkg::*;
#(
  parameter int NUM_TYPES       = 128,
  parameter int NUM_TRANSITIONS = 32,
  parameter int DAMAGE_BITS     = 17
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  pst_in_t  req,
  output logic     done,
  output pst_out_t rsp
);

  `include "per_type_record_statistics_defines.svh"

  localparam int TYPE_AW  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int TRANS_AW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
  localparam int BIT_AW   = (DAMAGE_BITS > 1) ? $clog2(DAMAGE_BITS) : 1;

  pst_state_t                   state;
  pst_state_t                   state_next;
  pst_in_t                      req_q;
  pst_ctl_t                     ctl;
  logic                         clearing;
  stat_row_t                    stat_q;
  logic [DAMAGE_BITS-1:0][31:0] dmg_q;
  logic                         late;
  logic [31:0]                  trans_val;
  logic [31:0]                  bit_val;
  logic                         ty_ok;
  logic [5:0]                   tidx;
  logic [31:0]                  val;
  pst_out_t                     rsp_next;

  pst_type_table #(
    .NUM_TYPES   (NUM_TYPES),
    .DAMAGE_BITS (DAMAGE_BITS),
    .TYPE_AW     (TYPE_AW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_addr  (TYPE_AW'(req.type_id)),
    .rec      (req_q),
    .clearing (clearing),
    .stat_q   (stat_q),
    .dmg_q    (dmg_q)
  );

  pst_global #(
    .NUM_TRANSITIONS (NUM_TRANSITIONS),
    .DAMAGE_BITS     (DAMAGE_BITS),
    .TRANS_AW        (TRANS_AW),
    .BIT_AW          (BIT_AW)
  ) u_global (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rec       (req_q),
    .late      (late),
    .trans_val (trans_val),
    .bit_val   (bit_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) req_q <= req;
    if (state == ST_EXEC) rsp <= rsp_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (!clearing) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ty_ok         = int'(req_q.type_id) < NUM_TYPES;
    busy          = (state != ST_IDLE);
    ctl.rd        = (state == ST_IDLE) && start;
    ctl.upd_rec   = (state == ST_EXEC) && (req_q.req_type == REQ_RECORD) && ty_ok;
    ctl.upd_dgram = (state == ST_EXEC) && (req_q.req_type == REQ_DGRAM);
  end

  always_comb begin
    tidx = req_q.stat_select - SEL_TB_BASE;
    val  = 32'd0;
    if (req_q.stat_select == SEL_TRANS) begin
      val = trans_val;
    end else if (req_q.stat_select >= SEL_BT_BASE) begin
      val = bit_val;
    end else if (!ty_ok) begin
      val = 32'd0;
    end else if (req_q.stat_select >= SEL_TB_BASE) begin
      if (int'(tidx) < DAMAGE_BITS) val = dmg_q[tidx[BIT_AW-1:0]];
    end else begin
      case (req_q.stat_select)
        SEL_ENTRIES: val = stat_q.entries;
        SEL_ZERO:    val = stat_q.zero_cnt;
        SEL_PMIN:    val = 32'(stat_q.pay_min);
        SEL_PMAX:    val = 32'(stat_q.pay_max);
        SEL_VMIN:    val = 32'(stat_q.ver_min);
        SEL_VMAX:    val = 32'(stat_q.ver_max);
        SEL_LMIN:    val = 32'(stat_q.log_min);
        SEL_LMAX:    val = 32'(stat_q.log_max);
        SEL_SMIN:    val = stat_q.phy_min;
        SEL_SMAX:    val = stat_q.phy_max;
        SEL_LVMIN:   val = 32'(stat_q.lvl_min);
        SEL_LVMAX:   val = 32'(stat_q.lvl_max);
        SEL_DMIN:    val = 32'(stat_q.dep_min);
        SEL_DMAX:    val = 32'(stat_q.dep_max);
        SEL_DTOTAL:  val = stat_q.dmg_total;
        default:     val = 32'd0;
      endcase
    end
  end

  always_comb begin
    rsp_next = '0;
    case (req_q.req_type)
      REQ_DGRAM: rsp_next.time_out_of_order = late;
      REQ_RECORD: begin
        rsp_next.any_damage = (req_q.damage_word != '0);
        rsp_next.stop_walk  = req_q.damage_word[STOP_BIT];
      end
      REQ_READ: rsp_next.read_value = val;
      default:  rsp_next = '0;
    endcase
  end

  `PST_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `PST_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `PST_ASSERT_NOW(a_accept_done, clk, rst, start && !busy, ##2 done)
  `PST_ASSERT_NEXT(a_done_single, clk, rst, done, !done)

endmodule

### tb/sv/pst_checker.sv
// ----------------------------------------------------------------------------
// pst_checker
// Watches request and result beats of the record statistics block, keeps its
// own copy of the statistics tables, predicts each result and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pst_checker
  import pst_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  pst_in_t  req,
  input  logic     done,
  input  pst_out_t rsp,
  output int       fail_count,
  output int       pending
);

  localparam int N_TYPES = 128;
  localparam int N_TRANS = 32;
  localparam int N_BITS  = 17;

  logic [31:0] trans_cnt [N_TRANS];
  logic [31:0] entry_cnt [N_TYPES];
  logic [31:0] zero_cnt [N_TYPES];
  logic [31:0] dmg_total [N_TYPES];
  logic [31:0] min_tab [N_TYPES][6];
  logic [31:0] max_tab [N_TYPES][6];
  logic [31:0] type_bit_cnt [N_TYPES][N_BITS];
  logic [31:0] bit_total [N_BITS];
  logic [63:0] last_stamp;
  pst_out_t    expected_rsp [$];

  function automatic logic [31:0] read_statistic(logic [5:0] s, logic [4:0] tr,
                                                 logic [6:0] ty);
    if (s == SEL_TRANS) return trans_cnt[tr];
    if (s > SEL_LAST) return 32'd0;
    if (s >= SEL_BT_BASE) return bit_total[s - SEL_BT_BASE];
    if (s >= SEL_TB_BASE) return type_bit_cnt[ty][s - SEL_TB_BASE];
    case (s)
      SEL_ENTRIES: return entry_cnt[ty];
      SEL_ZERO:    return zero_cnt[ty];
      SEL_DTOTAL:  return dmg_total[ty];
      default: begin
        if (s[0]) return min_tab[ty][(s - SEL_PMIN) / 2];
        return max_tab[ty][(s - SEL_PMIN) / 2];
      end
    endcase
  endfunction

  task automatic apply_beat(pst_in_t b);
    pst_out_t    r;
    logic [31:0] v [6];
    r = '0;
    case (b.req_type)
      REQ_DGRAM: begin
        r.time_out_of_order = last_stamp > b.time_stamp;
        last_stamp = b.time_stamp;
        trans_cnt[b.transition_id]++;
      end
      REQ_RECORD: begin
        r.any_damage = b.damage_word != 0;
        r.stop_walk  = b.damage_word[STOP_BIT];
        entry_cnt[b.type_id]++;
        if (b.payload_size == 0) zero_cnt[b.type_id]++;
        v = '{32'(b.payload_size), 32'(b.type_version), 32'(b.source_log),
              b.source_phy, 32'(b.source_level), 32'(b.nest_depth)};
        for (int k = 0; k < 6; k++) begin
          if (v[k] < min_tab[b.type_id][k]) min_tab[b.type_id][k] = v[k];
          if (v[k] > max_tab[b.type_id][k]) max_tab[b.type_id][k] = v[k];
        end
        for (int k = 0; k < N_BITS; k++) begin
          if (b.damage_word[k]) begin
            type_bit_cnt[b.type_id][k]++;
            dmg_total[b.type_id]++;
            bit_total[k]++;
          end
        end
      end
      REQ_READ: r.read_value = read_statistic(b.stat_select, b.transition_id, b.type_id);
      default: ;
    endcase
    expected_rsp = {expected_rsp, r};
  endtask

  initial begin
    fail_count = 0;
    last_stamp = '0;
    for (int i = 0; i < N_TRANS; i++) trans_cnt[i] = '0;
    for (int k = 0; k < N_BITS; k++) bit_total[k] = '0;
    for (int t = 0; t < N_TYPES; t++) begin
      entry_cnt[t] = '0;
      zero_cnt[t] = '0;
      dmg_total[t] = '0;
      min_tab[t] = '{32'd11111111, 32'd111, 32'd11111111, 32'd1111111111,
                     32'd11111111, 32'd11111111};
      for (int k = 0; k < 6; k++) max_tab[t][k] = '0;
      for (int k = 0; k < N_BITS; k++) type_bit_cnt[t][k] = '0;
    end
  end

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    pst_out_t e;
    if (!rst) begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", rsp);
        end else begin
          e = expected_rsp.pop_front();
          if (rsp.time_out_of_order !== e.time_out_of_order ||
              rsp.any_damage !== e.any_damage || rsp.stop_walk !== e.stop_walk ||
              rsp.read_value !== e.read_value) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected late=%b dmg=%b stop=%b val=%h, got %b %b %b %h",
                       e.time_out_of_order, e.any_damage, e.stop_walk, e.read_value,
                       rsp.time_out_of_order, rsp.any_damage, rsp.stop_walk,
                       rsp.read_value);
          end
        end
      end
      if (start && !busy) apply_beat(req);
    end
  end

endmodule

### tb/sv/tb_per_type_record_statistics.sv
// ----------------------------------------------------------------------------
// tb_per_type_record_statistics
// Drives datagram, record and read requests with random gaps into the
// record statistics block; a checker beside it predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_per_type_record_statistics;
  import pst_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  pst_in_t  req;
  logic     done;
  pst_out_t rsp;
  int       fail_count;
  int       pending;
  int       beats_sent;
  int       reads_sent;

  per_type_record_statistics dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  pst_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic pst_in_t random_beat(logic [1:0] kind);
    pst_in_t b;
    b.req_type      = kind;
    b.transition_id = 5'($urandom);
    b.time_stamp    = {$urandom, $urandom};
    b.type_id       = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 5));
    b.payload_size  = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom);
    b.type_version  = 15'($urandom);
    b.source_log    = 24'($urandom);
    b.source_phy    = $urandom;
    b.source_level  = 8'($urandom);
    b.nest_depth    = 8'($urandom);
    b.damage_word   = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom & $urandom;
    b.stat_select   = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 49));
    return b;
  endfunction

  task automatic send(pst_in_t b);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req   <= b;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    beats_sent++;
    if (b.req_type == REQ_READ) reads_sent++;
  endtask

  initial begin
    pst_in_t b;
    int      cycles;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    beats_sent = 0;
    reads_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Extremes: reads of untouched rows, field limits, late time and request type 3.
    b = '0; b.req_type = REQ_READ; b.stat_select = SEL_PMIN; send(b);
    b.stat_select = SEL_SMIN; send(b);
    b.stat_select = 6'd63; send(b);
    b = '1; b.req_type = REQ_DGRAM; send(b);
    b.time_stamp = '0; b.transition_id = '0; send(b);
    b = '1; b.req_type = REQ_RECORD; send(b);
    b = '0; b.req_type = REQ_RECORD; b.type_id = 7'd127; send(b);
    b.damage_word = 32'h0000_8000; b.type_id = '0; send(b);
    b = '1; send(b);
    b = '0; b.req_type = REQ_READ; b.transition_id = '1; send(b);
    for (int s = 1; s <= 15; s++) begin
      b.type_id = 7'd127; b.stat_select = 6'(s); send(b);
    end
    b.stat_select = 6'd32; send(b);
    b.stat_select = SEL_LAST; send(b);

    for (int i = 0; i < 1750; i++) begin
      b = random_beat(2'($urandom_range(0, 9) < 1 ? 3 : $urandom_range(0, 2)));
      send(b);
    end
    start <= 1'b0;

    cycles = 0;
    while (pending != 0 && cycles < 10000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (5) @(posedge clk);
    $display("Sent %0d request beats, %0d of them statistic reads,", beats_sent, reads_sent);
    $display("covering datagrams, records, idle codes and every read selector.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
